// ===== hdl/xtea_pkg.sv =====
// ----------------------------------------------------------------------------
// XTEA package
// Shared types, constants and per-stage constants of the XTEA pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package xtea_pkg;

   localparam int ROUND_PAIRS = 32;
   localparam int STAGES      = 2 * ROUND_PAIRS;
   localparam int WORD_W      = 32;
   localparam int KEY_WORDS   = 4;
   localparam int KEY_IDX_W   = $clog2(KEY_WORDS);

   localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9E37_79B9;

   typedef logic [WORD_W-1:0] word_type;

   typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_type;

   typedef enum logic [KEY_IDX_W-1:0] {
      KEY_WORD_ZERO  = 2'd0,
      KEY_WORD_ONE   = 2'd1,
      KEY_WORD_TWO   = 2'd2,
      KEY_WORD_THREE = 2'd3
   } key_reg_type;

   typedef struct packed {
      word_type first;
      word_type second;
   } block_type;

   // Running sum seen by a half-round: even stages use the sum before the
   // delta step, odd stages the sum after it.
   function automatic word_type stage_sum(input int stage);
      int       pairs;
      word_type prod;
      begin
         pairs = (stage + 1) >> 1;
         prod  = XTEA_DELTA * word_type'(pairs);
         return prod;
      end
   endfunction

   function automatic logic [KEY_IDX_W-1:0] stage_key_index(input int stage);
      word_type s;
      begin
         s = stage_sum(stage);
         if (stage[0] == 1'b0) begin
            return s[KEY_IDX_W-1:0];
         end else begin
            return s[11 +: KEY_IDX_W];
         end
      end
   endfunction

   function automatic word_type mix_word(input word_type w);
      return ((w << 4) ^ (w >> 5)) + w;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/xtea_key_regs.sv =====
// ----------------------------------------------------------------------------
// XTEA key registers
// Four 32-bit key words written through the plain CSR write port.
// ----------------------------------------------------------------------------
`default_nettype none

module xtea_key_regs (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write_enable,
   input  wire logic [xtea_pkg::KEY_IDX_W-1:0] csr_index,
   input  wire logic [xtea_pkg::WORD_W-1:0]    csr_data,
   output      xtea_pkg::key_type          key
);
   import xtea_pkg::*;

   key_type key_ff;
   key_type key_in;

   always_comb begin
      key_in = key_ff;
      if (csr_write_enable) begin
         unique case (key_reg_type'(csr_index))
            KEY_WORD_ZERO:  key_in[0] = csr_data;
            KEY_WORD_ONE:   key_in[1] = csr_data;
            KEY_WORD_TWO:   key_in[2] = csr_data;
            KEY_WORD_THREE: key_in[3] = csr_data;
            default:        key_in    = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign key = key_ff;

endmodule

`default_nettype wire

// ===== hdl/xtea_stage.sv =====
// ----------------------------------------------------------------------------
// XTEA half-round stage
// One registered half-round with its own valid bit and ready back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module xtea_stage (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    odd_half,
   input  wire logic [xtea_pkg::WORD_W-1:0] round_sum,
   input  wire logic [xtea_pkg::WORD_W-1:0] key_word,
   input  wire logic                    up_valid,
   output      logic                    up_ready,
   input  wire xtea_pkg::block_type     up_data,
   output      logic                    dn_valid,
   input  wire logic                    dn_ready,
   output      xtea_pkg::block_type     dn_data
);
   import xtea_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   block_type data_ff;
   block_type data_in;
   word_type  src;
   word_type  dst;
   word_type  upd;

   assign up_ready = !valid_ff || dn_ready;

   always_comb begin
      src = odd_half ? up_data.first  : up_data.second;
      dst = odd_half ? up_data.second : up_data.first;
      upd = dst + (mix_word(src) ^ (round_sum + key_word));
      data_in = up_data;
      if (odd_half) begin
         data_in.second = upd;
      end else begin
         data_in.first = upd;
      end
      valid_in = up_ready ? up_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold the payload while stalled
   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

// ===== hdl/xtea_block_encrypt.sv =====
// ----------------------------------------------------------------------------
// XTEA block encrypt
// Fully unrolled XTEA encryption pipeline, one 64-bit block per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Load the 128-bit key through the csr_ port (index 0..3 = key words
//   zero..three) while the pipeline is empty; the key resets to all zero.
//   Present plaintext beats on the req_ channel (valid/ready); ciphertext
//   beats leave on the rsp_ channel in the same order.
// Pipeline and throughput:
//   Each round pair is split into two half-round stages; the last stage
//   register drives the rsp_ channel directly.
//   One beat enters every cycle unless a low rsp_ready has filled the
//   pipeline; each stage holds one adder chain of mix + add, with the round
//   sum fixed per stage at elaboration.
// Stalls:
//   Every stage carries its own valid bit and may load whenever it is empty
//   or its successor takes its beat, so bubbles close up while rsp_ready is
//   low and req_ready stays high until the whole pipeline is full.
//   Nothing is dropped or repeated across a stall.
// Reset:
//   Synchronous, active high; clears all valid bits and the key words.
// ----------------------------------------------------------------------------
`default_nettype none

module xtea_block_encrypt (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_write_enable,
   input  wire logic [xtea_pkg::KEY_IDX_W-1:0] csr_index,
   input  wire logic [xtea_pkg::WORD_W-1:0]    csr_data,
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire logic [xtea_pkg::WORD_W-1:0]    req_plain_first,
   input  wire logic [xtea_pkg::WORD_W-1:0]    req_plain_second,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      logic [xtea_pkg::WORD_W-1:0]    rsp_cipher_first,
   output      logic [xtea_pkg::WORD_W-1:0]    rsp_cipher_second
);
   import xtea_pkg::*;

   key_type   key;
   // link i feeds stage i; link STAGES is the output of the last stage
   logic      link_valid [STAGES+1];
   logic      link_ready [STAGES+1];
   block_type link_data  [STAGES+1];

   xtea_key_regs u_key_regs (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .key              (key)
   );

   // input side
   assign link_valid[0]       = req_valid;
   assign req_ready           = link_ready[0];
   assign link_data[0].first  = req_plain_first;
   assign link_data[0].second = req_plain_second;

   genvar s;
   generate
      for (s = 0; s < STAGES; s++) begin : g_stage
         // round sum and key word choice are fixed per stage
         localparam word_type              SUM = stage_sum(s);
         localparam logic [KEY_IDX_W-1:0]  KIX = stage_key_index(s);
         localparam logic                  ODD = (s % 2) == 1;

         xtea_stage u_stage (
            .clock     (clock),
            .reset     (reset),
            .odd_half  (ODD),
            .round_sum (SUM),
            .key_word  (key[KIX]),
            .up_valid  (link_valid[s]),
            .up_ready  (link_ready[s]),
            .up_data   (link_data[s]),
            .dn_valid  (link_valid[s+1]),
            .dn_ready  (link_ready[s+1]),
            .dn_data   (link_data[s+1])
         );
      end
   endgenerate

   // output side: the last stage register is the result register
   assign rsp_valid          = link_valid[STAGES];
   assign link_ready[STAGES] = rsp_ready;
   assign rsp_cipher_first   = link_data[STAGES].first;
   assign rsp_cipher_second  = link_data[STAGES].second;

endmodule

`default_nettype wire
